// ----- rtl/ludm_pkg.sv -----
`default_nettype none
// ============================================================================
// ludm_pkg
// Shared types, constants and saturating helpers for the lens undistortion
// map generator: Q.28 intermediate format, register map, pipeline latencies.
// ============================================================================
package ludm_pkg;

  // Signed Q.28 intermediate, always kept within +-(2^62 - 1)
  typedef logic signed [62:0] q_t;

  localparam q_t LIM   = 63'sh3FFF_FFFF_FFFF_FFFF;
  localparam q_t ONE_Q = 63'sd268435456;   // 1.0 in Q.28
  localparam q_t HALF_PX = 63'sd2048;      // half a pixel in Q.12

  localparam logic signed [63:0] LIM64 = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Field and register widths
  localparam int FOCAL_W  = 24;
  localparam int CENTER_W = 23;
  localparam int UMAG_W   = 23;                 // |pixel - center| in Q.12
  localparam int FRAC_W   = 28;
  localparam int DIV_STEPS = UMAG_W + FRAC_W;   // quotient bits of normalize

  // Multiplier pipeline depth
  localparam int MUL_LAT = 5;

  // Reset values of the configuration registers
  localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 24'd2150400;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 23'd1308672;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 23'd980992;

  // Register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_RADIAL_K3  = 3'd6,
    REG_TANGENTIAL = 3'd7
  } reg_idx_e;

  // Saturating add of two in-range values
  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    if (s > LIM64) begin
      return LIM;
    end else if (s < -LIM64) begin
      return -LIM;
    end else begin
      return q_t'(s);
    end
  endfunction

  // Sign-extend a 32-bit coefficient
  function automatic q_t sext32(input logic [31:0] c);
    return q_t'({{31{c[31]}}, c});
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ludm_mulq.sv -----
`default_nettype none
// ============================================================================
// ludm_mulq
// Pipelined Q.28 multiplier: sign/magnitude split, four 31x31 partial
// products, recombination, then shift by 28 with saturation and sign.
// ============================================================================
module ludm_mulq (
  input  logic          clk_i,
  input  logic          en_i,
  input  ludm_pkg::q_t  a_i,
  input  ludm_pkg::q_t  b_i,
  input  logic          neg_i,
  output ludm_pkg::q_t  p_o
);
  import ludm_pkg::*;

  logic [62:0]  abs_a, abs_b;
  logic         sgn1_q, sgn2_q, sgn3_q, sgn4_q;
  logic [61:0]  ma_q, mb_q;
  logic [61:0]  p00_q, p01_q, p10_q, p11_q;
  logic [61:0]  lo3_q, hi3_q;
  logic [62:0]  cross_q;
  logic [123:0] full_q;
  logic [95:0]  shv;
  logic [61:0]  mag5;
  q_t           p_q;

  // stage 1: magnitudes and product sign
  assign abs_a = a_i[62] ? 63'(-a_i) : 63'(a_i);
  assign abs_b = b_i[62] ? 63'(-b_i) : 63'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn1_q <= a_i[62] ^ b_i[62] ^ neg_i;
      ma_q   <= abs_a[61:0];
      mb_q   <= abs_b[61:0];
    end
  end

  // stage 2: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn2_q <= sgn1_q;
      p00_q  <= 62'(ma_q[30:0]) * 62'(mb_q[30:0]);
      p01_q  <= 62'(ma_q[30:0]) * 62'(mb_q[61:31]);
      p10_q  <= 62'(ma_q[61:31]) * 62'(mb_q[30:0]);
      p11_q  <= 62'(ma_q[61:31]) * 62'(mb_q[61:31]);
    end
  end

  // stage 3: cross terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn3_q  <= sgn2_q;
      lo3_q   <= p00_q;
      hi3_q   <= p11_q;
      cross_q <= 63'(p01_q) + 63'(p10_q);
    end
  end

  // stage 4: full 124-bit product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn4_q <= sgn3_q;
      full_q <= {hi3_q, lo3_q} + {30'b0, cross_q, 31'b0};
    end
  end

  // stage 5: drop fraction bits, saturate, apply sign
  assign shv  = full_q[123:28];
  assign mag5 = (|shv[95:62]) ? LIM[61:0] : shv[61:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sgn4_q ? -q_t'({1'b0, mag5}) : q_t'({1'b0, mag5});
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ----- rtl/lens_undistort_map_generator_top.sv -----
`default_nettype none
// ============================================================================
// lens_undistort_map_generator_top
// Brown-Conrady source pixel generator: normalize, distort, rescale, round
// and saturate, one pixel coordinate per clock unless held by stall_i.
// ============================================================================
// Throughput: one word per cycle; the whole pipeline advances together and
//   holds only while a result waits at the output under stall_i.
// Depth is set by the 51-step restoring divider of the normalize stage and
//   six levels of pipelined multipliers.
// Reset clears all valid bits and loads the default lens registers.
module lens_undistort_map_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [9:0]  pixel_column_i,
  input  logic [8:0]  pixel_row_i,
  input  logic        inverse_map_i,
  // source pixel output
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [11:0] source_column_o,
  output logic signed [11:0] source_row_o
);
  import ludm_pkg::*;

  // Stage positions along the pipeline
  localparam int M      = MUL_LAT;
  localparam int S      = DIV_STEPS;
  localparam int ST_X   = 3 + S;            // normalized x, y
  localparam int ST_L1  = ST_X + M;         // x*x, y*y, x*y
  localparam int ST_R   = ST_L1 + 1;        // r, 2x^2, 2y^2
  localparam int ST_RXY = ST_R + 1;         // r + 2x^2, r + 2y^2
  localparam int ST_T2  = ST_L1 + M + 1;    // doubled tangential cross terms
  localparam int ST_B1  = ST_R + 3 * M + 1; // radial partial sums
  localparam int ST_B2  = ST_B1 + 1;        // radial factor
  localparam int ST_C1  = ST_B2 + M + 1;
  localparam int ST_C2  = ST_C1 + 1;        // distorted x, y
  localparam int ST_D1  = ST_C2 + M + 1;    // plus center
  localparam int ST_D2  = ST_D1 + 1;        // plus half pixel
  localparam int ST_D3  = ST_D2 + 1;        // magnitude
  localparam int ST_OUT = ST_D3 + 1;        // rounded, saturated
  localparam int DEPTH  = ST_OUT + 1;

  // Delay line lengths
  localparam int XY_DLY  = ST_B2 - ST_X;
  localparam int K1R_DLY = 2 * M;
  localparam int T1_DLY  = ST_C1 - 1 - ST_T2;
  localparam int T2_DLY  = ST_C2 - 1 - ST_T2;
  localparam int PRX_DLY = ST_C2 - 1 - (ST_RXY + M);
  localparam int PRY_DLY = ST_C1 - 1 - (ST_RXY + M);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [31:0]         radial_k1_q, radial_k2_q, radial_k3_q;
  logic [63:0]         tangential_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= FOCAL_RST;
      focal_y_q    <= FOCAL_RST;
      center_x_q   <= CENTER_X_RST;
      center_y_q   <= CENTER_Y_RST;
      radial_k1_q  <= '0;
      radial_k2_q  <= '0;
      radial_k3_q  <= '0;
      tangential_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FOCAL_X:    focal_x_q    <= pwdata[FOCAL_W-1:0];
        REG_FOCAL_Y:    focal_y_q    <= pwdata[FOCAL_W-1:0];
        REG_CENTER_X:   center_x_q   <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:   center_y_q   <= pwdata[CENTER_W-1:0];
        REG_RADIAL_K1:  radial_k1_q  <= pwdata[31:0];
        REG_RADIAL_K2:  radial_k2_q  <= pwdata[31:0];
        REG_RADIAL_K3:  radial_k3_q  <= pwdata[31:0];
        REG_TANGENTIAL: tangential_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_FOCAL_X:    prdata = {40'b0, focal_x_q};
      REG_FOCAL_Y:    prdata = {40'b0, focal_y_q};
      REG_CENTER_X:   prdata = {41'b0, center_x_q};
      REG_CENTER_Y:   prdata = {41'b0, center_y_q};
      REG_RADIAL_K1:  prdata = {32'b0, radial_k1_q};
      REG_RADIAL_K2:  prdata = {32'b0, radial_k2_q};
      REG_RADIAL_K3:  prdata = {32'b0, radial_k3_q};
      REG_TANGENTIAL: prdata = tangential_q;
      default:        prdata = '0;
    endcase
  end

  // zero focal length acts as one LSB
  logic [FOCAL_W-1:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x_q == '0) ? FOCAL_W'(1) : focal_x_q;
  assign fy_eff = (focal_y_q == '0) ? FOCAL_W'(1) : focal_y_q;

  q_t k1_c, k2_c, k3_c, p1_c, p2_c;
  assign k1_c = sext32(radial_k1_q);
  assign k2_c = sext32(radial_k2_q);
  assign k3_c = sext32(radial_k3_q);
  assign p1_c = sext32(tangential_q[31:0]);
  assign p2_c = sext32(tangential_q[63:32]);

  // --------------------------------------------------------------------------
  // Pipeline control: valid and inverse flag travel with every stage
  // --------------------------------------------------------------------------
  logic             adv;
  logic [DEPTH-1:0] valid_q;
  logic [DEPTH-1:0] inv_q;

  assign adv     = !valid_q[ST_OUT] || !stall_i;
  assign stall_o = !adv;
  assign valid_o = valid_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv_q <= {inv_q[DEPTH-2:0], inverse_map_i};
    end
  end

  // --------------------------------------------------------------------------
  // Offset from principal point and magnitude
  // --------------------------------------------------------------------------
  logic [9:0]          col_q;
  logic [8:0]          row_q;
  logic signed [24:0]  ux_q, uy_q;
  logic [24:0]         ux_abs, uy_abs;

  assign ux_abs = ux_q[24] ? 25'(-ux_q) : 25'(ux_q);
  assign uy_abs = uy_q[24] ? 25'(-uy_q) : 25'(uy_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q <= pixel_column_i;
      row_q <= pixel_row_i;
      ux_q  <= $signed({3'b0, col_q, 12'b0}) - $signed({2'b0, center_x_q});
      uy_q  <= $signed({4'b0, row_q, 12'b0}) - $signed({2'b0, center_y_q});
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [FOCAL_W-1:0] rem_x_q [S+1];
  logic [FOCAL_W-1:0] rem_y_q [S+1];
  logic [S-1:0]       nq_x_q  [S+1];
  logic [S-1:0]       nq_y_q  [S+1];
  logic [S:0]         neg_x_q, neg_y_q;
  logic [FOCAL_W-1:0] rem_x_d [S+1];
  logic [FOCAL_W-1:0] rem_y_d [S+1];
  logic [S-1:0]       nq_x_d  [S+1];
  logic [S-1:0]       nq_y_d  [S+1];

  always_comb begin
    logic [FOCAL_W:0] tx, ty;
    logic             gx, gy;
    rem_x_d[0] = '0;
    rem_y_d[0] = '0;
    nq_x_d[0]  = {ux_abs[UMAG_W-1:0], {FRAC_W{1'b0}}};
    nq_y_d[0]  = {uy_abs[UMAG_W-1:0], {FRAC_W{1'b0}}};
    for (int j = 1; j <= S; j++) begin
      tx = {rem_x_q[j-1], nq_x_q[j-1][S-1]};
      ty = {rem_y_q[j-1], nq_y_q[j-1][S-1]};
      gx = (tx >= {1'b0, fx_eff});
      gy = (ty >= {1'b0, fy_eff});
      rem_x_d[j] = gx ? FOCAL_W'(tx - {1'b0, fx_eff}) : tx[FOCAL_W-1:0];
      rem_y_d[j] = gy ? FOCAL_W'(ty - {1'b0, fy_eff}) : ty[FOCAL_W-1:0];
      nq_x_d[j]  = {nq_x_q[j-1][S-2:0], gx};
      nq_y_d[j]  = {nq_y_q[j-1][S-2:0], gy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_x_q <= {neg_x_q[S-1:0], ux_q[24]};
      neg_y_q <= {neg_y_q[S-1:0], uy_q[24]};
      for (int j = 0; j <= S; j++) begin
        rem_x_q[j] <= rem_x_d[j];
        rem_y_q[j] <= rem_y_d[j];
        nq_x_q[j]  <= nq_x_d[j];
        nq_y_q[j]  <= nq_y_d[j];
      end
    end
  end

  // signed normalized coordinates
  q_t x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= neg_x_q[S] ? -q_t'({12'b0, nq_x_q[S]}) : q_t'({12'b0, nq_x_q[S]});
      y_q <= neg_y_q[S] ? -q_t'({12'b0, nq_y_q[S]}) : q_t'({12'b0, nq_y_q[S]});
    end
  end

  // --------------------------------------------------------------------------
  // Squares, cross term and radius
  // --------------------------------------------------------------------------
  q_t xsq, ysq, xy;
  q_t r_q, xsq2_q, ysq2_q, rx_q, ry_q;

  ludm_mulq u_mul_xsq (.clk_i, .en_i(adv), .a_i(x_q), .b_i(x_q), .neg_i(1'b0), .p_o(xsq));
  ludm_mulq u_mul_ysq (.clk_i, .en_i(adv), .a_i(y_q), .b_i(y_q), .neg_i(1'b0), .p_o(ysq));
  ludm_mulq u_mul_xy  (.clk_i, .en_i(adv), .a_i(x_q), .b_i(y_q), .neg_i(1'b0), .p_o(xy));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q    <= sadd(xsq, ysq);
      xsq2_q <= sadd(xsq, xsq);
      ysq2_q <= sadd(ysq, ysq);
      rx_q   <= sadd(r_q, xsq2_q);
      ry_q   <= sadd(r_q, ysq2_q);
    end
  end

  // --------------------------------------------------------------------------
  // Radial powers and coefficient products
  // --------------------------------------------------------------------------
  q_t r2, r3, k1r, k2r2, k3r3;
  q_t t1, t2, prx, pry;
  q_t t1x2_q, t2x2_q;
  q_t r_dq [M];

  ludm_mulq u_mul_r2 (.clk_i, .en_i(adv), .a_i(r_q), .b_i(r_q), .neg_i(1'b0), .p_o(r2));
  ludm_mulq u_mul_k1 (.clk_i, .en_i(adv), .a_i(k1_c), .b_i(r_q),
                      .neg_i(inv_q[ST_R]), .p_o(k1r));
  ludm_mulq u_mul_t1 (.clk_i, .en_i(adv), .a_i(p1_c), .b_i(xy),
                      .neg_i(inv_q[ST_L1]), .p_o(t1));
  ludm_mulq u_mul_t2 (.clk_i, .en_i(adv), .a_i(p2_c), .b_i(xy),
                      .neg_i(inv_q[ST_L1]), .p_o(t2));
  ludm_mulq u_mul_prx (.clk_i, .en_i(adv), .a_i(p2_c), .b_i(rx_q),
                       .neg_i(inv_q[ST_RXY]), .p_o(prx));
  ludm_mulq u_mul_pry (.clk_i, .en_i(adv), .a_i(p1_c), .b_i(ry_q),
                       .neg_i(inv_q[ST_RXY]), .p_o(pry));
  ludm_mulq u_mul_r3 (.clk_i, .en_i(adv), .a_i(r2), .b_i(r_dq[M-1]),
                      .neg_i(1'b0), .p_o(r3));
  ludm_mulq u_mul_k2 (.clk_i, .en_i(adv), .a_i(k2_c), .b_i(r2),
                      .neg_i(inv_q[ST_R+M]), .p_o(k2r2));
  ludm_mulq u_mul_k3 (.clk_i, .en_i(adv), .a_i(k3_c), .b_i(r3),
                      .neg_i(inv_q[ST_R+2*M]), .p_o(k3r3));

  // doubled tangential cross terms
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1x2_q <= sadd(t1, t1);
      t2x2_q <= sadd(t2, t2);
    end
  end

  // --------------------------------------------------------------------------
  // Alignment delay lines
  // --------------------------------------------------------------------------
  q_t x_dq   [XY_DLY];
  q_t y_dq   [XY_DLY];
  q_t k1r_dq [K1R_DLY];
  q_t k2r2_dq[M];
  q_t t1_dq  [T1_DLY];
  q_t t2_dq  [T2_DLY];
  q_t prx_dq [PRX_DLY];
  q_t pry_dq [PRY_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_dq[0]    <= x_q;
      y_dq[0]    <= y_q;
      r_dq[0]    <= r_q;
      k1r_dq[0]  <= k1r;
      k2r2_dq[0] <= k2r2;
      t1_dq[0]   <= t1x2_q;
      t2_dq[0]   <= t2x2_q;
      prx_dq[0]  <= prx;
      pry_dq[0]  <= pry;
      for (int i = 1; i < XY_DLY; i++) begin
        x_dq[i] <= x_dq[i-1];
        y_dq[i] <= y_dq[i-1];
      end
      for (int i = 1; i < M; i++) begin
        r_dq[i]    <= r_dq[i-1];
        k2r2_dq[i] <= k2r2_dq[i-1];
      end
      for (int i = 1; i < K1R_DLY; i++) begin
        k1r_dq[i] <= k1r_dq[i-1];
      end
      for (int i = 1; i < T1_DLY; i++) begin
        t1_dq[i] <= t1_dq[i-1];
      end
      for (int i = 1; i < T2_DLY; i++) begin
        t2_dq[i] <= t2_dq[i-1];
      end
      for (int i = 1; i < PRX_DLY; i++) begin
        prx_dq[i] <= prx_dq[i-1];
      end
      for (int i = 1; i < PRY_DLY; i++) begin
        pry_dq[i] <= pry_dq[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Radial factor 1 + k1 r + k2 r^2 + k3 r^3
  // --------------------------------------------------------------------------
  q_t sa_q, sb_q, rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q  <= sadd(ONE_Q, k1r_dq[K1R_DLY-1]);
      sb_q  <= sadd(k2r2_dq[M-1], k3r3);
      rad_q <= sadd(sa_q, sb_q);
    end
  end

  // --------------------------------------------------------------------------
  // Distorted coordinates
  // --------------------------------------------------------------------------
  q_t xrad, yrad;
  q_t xs1_q, ys1_q, xd_q, yd_q;

  ludm_mulq u_mul_xrad (.clk_i, .en_i(adv), .a_i(x_dq[XY_DLY-1]), .b_i(rad_q),
                        .neg_i(1'b0), .p_o(xrad));
  ludm_mulq u_mul_yrad (.clk_i, .en_i(adv), .a_i(y_dq[XY_DLY-1]), .b_i(rad_q),
                        .neg_i(1'b0), .p_o(yrad));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xs1_q <= sadd(xrad, t1_dq[T1_DLY-1]);
      ys1_q <= sadd(yrad, pry_dq[PRY_DLY-1]);
      xd_q  <= sadd(xs1_q, prx_dq[PRX_DLY-1]);
      yd_q  <= sadd(ys1_q, t2_dq[T2_DLY-1]);
    end
  end

  // --------------------------------------------------------------------------
  // Back to pixels: scale, offset, round, saturate
  // --------------------------------------------------------------------------
  q_t mx, my;
  q_t px1_q, py1_q, px2_q, py2_q;
  logic        negx3_q, negy3_q;
  logic [61:0] magx3_q, magy3_q;
  logic [62:0] px2_abs, py2_abs;
  logic signed [11:0] col_o_q, row_o_q;

  ludm_mulq u_mul_fx (.clk_i, .en_i(adv), .a_i(xd_q), .b_i(q_t'({39'b0, fx_eff})),
                      .neg_i(1'b0), .p_o(mx));
  ludm_mulq u_mul_fy (.clk_i, .en_i(adv), .a_i(yd_q), .b_i(q_t'({39'b0, fy_eff})),
                      .neg_i(1'b0), .p_o(my));

  assign px2_abs = px2_q[62] ? 63'(-px2_q) : 63'(px2_q);
  assign py2_abs = py2_q[62] ? 63'(-py2_q) : 63'(py2_q);

  // truncate toward zero, clamp to signed 12 bits
  function automatic logic [11:0] pix_sat(input logic neg, input logic [61:0] mag);
    logic [49:0] qv;
    qv = mag[61:12];
    if (neg) begin
      return (qv > 50'd2048) ? 12'h800 : 12'(12'd0 - qv[11:0]);
    end else begin
      return (qv > 50'd2047) ? 12'h7FF : qv[11:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px1_q   <= sadd(mx, q_t'({40'b0, center_x_q}));
      py1_q   <= sadd(my, q_t'({40'b0, center_y_q}));
      px2_q   <= sadd(px1_q, HALF_PX);
      py2_q   <= sadd(py1_q, HALF_PX);
      negx3_q <= px2_q[62];
      negy3_q <= py2_q[62];
      magx3_q <= px2_abs[61:0];
      magy3_q <= py2_abs[61:0];
      col_o_q <= $signed(pix_sat(negx3_q, magx3_q));
      row_o_q <= $signed(pix_sat(negy3_q, magy3_q));
    end
  end

  assign source_column_o = col_o_q;
  assign source_row_o    = row_o_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q[0])
    else $error("accepted word did not enter the first stage");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("valid bits moved while the pipeline was held");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_X-1] |-> (rem_x_q[S] < fx_eff) && (rem_y_q[S] < fy_eff))
    else $error("divider remainder not below divisor");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_X] |-> (x_q < 63'sh8_0000_0000_0000) && (x_q > -63'sh8_0000_0000_0000))
    else $error("normalized x out of quotient range");

endmodule
`default_nettype wire
